// ----- hdl/bhkv_pkg.sv -----
package bhkv_pkg;

   localparam int BUCKETS   = 16;
   localparam int WAYS      = 4;
   localparam int KEY_BYTES = 8;

   localparam int SLOTS  = BUCKETS * WAYS;
   localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int FILL_W = $clog2(WAYS + 1);
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SUM_W  = 11;

   localparam logic [63:0] KEY_MASK = (KEY_BYTES >= 8) ? {64{1'b1}} :
                                      ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic signed [31:0] NOT_FOUND = -32'sd1;

   function automatic logic [BKT_W-1:0] bucket_of(input logic [63:0] k);
      logic [SUM_W-1:0] sum;
      sum = '0;
      for (int b = 0; b < 8; b++) begin
         sum = sum + SUM_W'(k[8*b +: 8]);
      end
      return BKT_W'(sum % BUCKETS);
   endfunction

   function automatic logic [SLOT_W-1:0] slot_addr(input logic [BKT_W-1:0] bkt,
                                                   input logic [FILL_W:0] way);
      return SLOT_W'(int'(bkt) * WAYS + int'(way));
   endfunction

endpackage

// ----- hdl/bhkv_chan_if.sv -----
interface bhkv_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [63:0]        key;
   logic signed [31:0] value;

   modport source (output valid, output opcode, output key, output value, input ready);
   modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

interface bhkv_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_value;
   logic [1:0]         status;

   modport source (output valid, output result_value, output status, input ready);
   modport sink   (input valid, input result_value, input status, output ready);
endinterface

// ----- hdl/bucketed_hash_key_value_store.sv -----
// Bucketed hash key-value store.
// req: one transfer carries opcode (insert, search, remove), a packed key and
// a value. rsp: exactly one transfer per request with result_value and status.
// The key bytes are summed modulo BUCKETS to pick a bucket of WAYS slots held
// in a slot memory with a write port and a separate registered read port.
// One request is processed at a time; req.ready is high only while idle.
// Steps from request transfer to rsp.valid: the request is hashed, then
// dispatched; an insert, or a search/remove on an empty bucket, then goes
// straight to the response state. A search/remove reads and compares the
// bucket's slots in turn (one memory read, one compare per slot); a remove hit
// then shifts each later entry down (read, then write). Compares and shifts
// together visit each filled slot of the bucket once; every compare and
// every shift step needs its own memory read.
// req.ready rises with rsp.valid.
// Reset clears the fill count of every bucket at once; no clearing pass is
// needed and requests are taken in the first cycle after reset.
// The response is held in an output register. A new request is taken while a
// response waits; if rsp stalls, the next response waits in its final state
// until the register is free.
module bucketed_hash_key_value_store
   import bhkv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bhkv_req_if.sink    req,
   bhkv_rsp_if.source  rsp
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_HASH,
      S_DISPATCH,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_RESP
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [63:0]        key_ff, key_in;
   logic signed [31:0] val_ff, val_in;
   logic [BKT_W-1:0]   bkt_ff, bkt_in;
   logic [FILL_W-1:0]  way_ff, way_in;
   logic signed [31:0] res_ff, res_in;
   logic [1:0]         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [FILL_W-1:0]  bucket_fill_ff [BUCKETS];
   logic [FILL_W-1:0]  bucket_fill_in [BUCKETS];

   logic [63:0]        slot_key_mem [SLOTS];
   logic signed [31:0] slot_val_mem [SLOTS];
   logic [63:0]        rd_key_ff;
   logic signed [31:0] rd_val_ff;

   logic               mem_we;
   logic [SLOT_W-1:0]  mem_waddr;
   logic [SLOT_W-1:0]  mem_raddr;
   logic [63:0]        mem_wkey;
   logic signed [31:0] mem_wval;

   logic [FILL_W-1:0]  cur_fill;
   logic [FILL_W:0]    way_x;
   logic [FILL_W:0]    way_p1;
   logic [FILL_W:0]    way_p2;
   logic [FILL_W:0]    fill_x;

   assign cur_fill = bucket_fill_ff[bkt_ff];
   assign way_x    = {1'b0, way_ff};
   assign way_p1   = way_x + (FILL_W+1)'(1);
   assign way_p2   = way_x + (FILL_W+1)'(2);
   assign fill_x   = {1'b0, cur_fill};

   assign req.ready        = (state_ff == S_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_value = rsp_value_ff;
   assign rsp.status       = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      bkt_in        = bkt_ff;
      way_in        = way_ff;
      res_in        = res_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      for (int i = 0; i < BUCKETS; i++) begin
         bucket_fill_in[i] = bucket_fill_ff[i];
      end
      mem_we    = 1'b0;
      mem_waddr = slot_addr(bkt_ff, way_x);
      mem_raddr = slot_addr(bkt_ff, way_x);
      mem_wkey  = key_ff;
      mem_wval  = val_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in    = req.opcode;
               key_in   = req.key & KEY_MASK;
               val_in   = req.value;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            bkt_in   = bucket_of(key_ff);
            state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            way_in    = '0;
            res_in    = NOT_FOUND;
            status_in = ST_DONE;
            state_in  = S_RESP;
            if (op_ff == OP_INSERT) begin
               if (fill_x >= (FILL_W+1)'(WAYS)) begin
                  status_in = ST_FULL;
               end else begin
                  mem_we                 = 1'b1;
                  mem_waddr              = slot_addr(bkt_ff, fill_x);
                  bucket_fill_in[bkt_ff] = cur_fill + FILL_W'(1);
               end
            end else if (op_ff == OP_SEARCH || op_ff == OP_REMOVE) begin
               if (cur_fill == '0) begin
                  status_in = ST_MISS;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (rd_key_ff == key_ff) begin
               if (op_ff == OP_SEARCH) begin
                  res_in   = rd_val_ff;
                  state_in = S_RESP;
               end else if (way_p1 < fill_x) begin
                  state_in = S_SHIFT_RD;
               end else begin
                  bucket_fill_in[bkt_ff] = cur_fill - FILL_W'(1);
                  state_in               = S_RESP;
               end
            end else if (way_p1 < fill_x) begin
               way_in   = way_ff + FILL_W'(1);
               state_in = S_SCAN_RD;
            end else begin
               status_in = ST_MISS;
               state_in  = S_RESP;
            end
         end
         S_SHIFT_RD: begin
            mem_raddr = slot_addr(bkt_ff, way_p1);
            state_in  = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_wkey  = rd_key_ff;
            mem_wval  = rd_val_ff;
            way_in    = way_ff + FILL_W'(1);
            if (way_p2 < fill_x) begin
               state_in = S_SHIFT_RD;
            end else begin
               bucket_fill_in[bkt_ff] = cur_fill - FILL_W'(1);
               state_in               = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < BUCKETS; i++) begin
            bucket_fill_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < BUCKETS; i++) begin
            bucket_fill_ff[i] <= bucket_fill_in[i];
         end
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      bkt_ff        <= bkt_in;
      way_ff        <= way_in;
      res_ff        <= res_in;
      status_ff     <= status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_key_mem[mem_waddr] <= mem_wkey;
         slot_val_mem[mem_waddr] <= mem_wval;
      end
      rd_key_ff <= slot_key_mem[mem_raddr];
      rd_val_ff <= slot_val_mem[mem_raddr];
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && state_ff != S_HASH) |-> (fill_x <= (FILL_W+1)'(WAYS)))
      else $error("bucket fill above WAYS");

   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (state_ff == S_HASH))
      else $error("accepted request not hashed next cycle");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && status_ff == ST_FULL) |-> (op_ff == OP_INSERT))
      else $error("full status on a non-insert");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && res_ff != NOT_FOUND) |-> (op_ff == OP_SEARCH))
      else $error("value returned on a non-search");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import bhkv_pkg::*;

   localparam logic [1:0] OP_NONE = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES = 40;
   localparam int ITEMS_PER_PHASE = 156;
   localparam int KEY_POOL_SIZE = 20;

   typedef struct {
      logic signed [31:0] result_value;
      logic [1:0]         status;
   } kv_resp_type;

   typedef struct {
      logic [1:0]  opcode;
      logic [63:0] key;
      logic [31:0] value;
      bit          typed;
      kv_resp_type resp;
   } kv_row_type;

   logic clock;
   logic reset;

   bhkv_req_if req_if ();
   bhkv_rsp_if rsp_if ();

   bucketed_hash_key_value_store u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // shadow table
   logic [63:0] shadow_key [BUCKETS][WAYS];
   logic [31:0] shadow_val [BUCKETS][WAYS];
   int          shadow_fill [BUCKETS];

   kv_resp_type pending_rsp[$];
   kv_row_type  seq_rows[$];
   logic [63:0] key_pool [KEY_POOL_SIZE];

   int send_idle_pct;
   int recv_stall_pct;
   int fail_count;
   int quiet_cycles;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic kv_resp_type apply_kv_op(input logic [1:0] op,
                                               input logic [63:0] key_in,
                                               input logic [31:0] val);
      kv_resp_type r;
      logic [63:0] k;
      int unsigned sum;
      int          b;
      int          hit;
      k = key_in & KEY_MASK;
      sum = 0;
      for (int i = 0; i < 8; i++) sum += k[8*i +: 8];
      b = sum % BUCKETS;
      r.result_value = NOT_FOUND;
      r.status = ST_DONE;
      hit = -1;
      for (int w = 0; w < shadow_fill[b]; w++) begin
         if (hit < 0 && shadow_key[b][w] == k) hit = w;
      end
      case (op)
         OP_INSERT: begin
            if (shadow_fill[b] >= WAYS) begin
               r.status = ST_FULL;
            end else begin
               shadow_key[b][shadow_fill[b]] = k;
               shadow_val[b][shadow_fill[b]] = val;
               shadow_fill[b]++;
            end
         end
         OP_SEARCH: begin
            if (hit < 0) r.status = ST_MISS;
            else r.result_value = shadow_val[b][hit];
         end
         OP_REMOVE: begin
            if (hit < 0) begin
               r.status = ST_MISS;
            end else begin
               for (int w = hit; w + 1 < shadow_fill[b]; w++) begin
                  shadow_key[b][w] = shadow_key[b][w+1];
                  shadow_val[b][w] = shadow_val[b][w+1];
               end
               shadow_fill[b]--;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void add_row(input logic [1:0] op, input logic [63:0] k,
                                   input logic [31:0] v, input bit typed,
                                   input logic [31:0] rv, input logic [1:0] st);
      kv_row_type row;
      row.opcode = op;
      row.key = k;
      row.value = v;
      row.typed = typed;
      row.resp.result_value = rv;
      row.resp.status = st;
      seq_rows.insert(seq_rows.size(), row);
   endfunction

   function automatic logic [63:0] rand_short_key();
      logic [63:0] k;
      int          len;
      k = {$urandom, $urandom};
      len = $urandom_range(8, 1);
      if (len < 8) k = k & ((64'd1 << (8 * len)) - 64'd1);
      return k;
   endfunction

   task automatic send_op(input kv_row_type row);
      kv_resp_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.opcode <= row.opcode;
      req_if.key    <= row.key;
      req_if.value  <= row.value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pred = apply_kv_op(row.opcode, row.key, row.value);
      pending_rsp.insert(pending_rsp.size(), row.typed ? row.resp : pred);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   task automatic note_fail(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   // response checker
   always @(posedge clock) begin : rsp_check
      kv_resp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_rsp.size() == 0) begin
            note_fail($sformatf("unexpected response value=%h status=%0d",
                                rsp_if.result_value, rsp_if.status));
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_if.result_value !== want.result_value)
               note_fail($sformatf("result_value mismatch: expected %h, got %h",
                                   want.result_value, rsp_if.result_value));
            if (rsp_if.status !== want.status)
               note_fail($sformatf("status mismatch: expected %0d, got %0d",
                                   want.status, rsp_if.status));
         end
      end
   end

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      kv_row_type  row;
      logic [63:0] k;
      int          r;
      int          b;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.opcode = OP_INSERT;
      req_if.key = '0;
      req_if.value = '0;
      rsp_if.ready = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      fail_count = 0;
      quiet_cycles = 0;
      for (int i = 0; i < BUCKETS; i++) shadow_fill[i] = 0;
      for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = rand_short_key();

      // keys 0, 'h10, 'h20 and 'h80 in the top byte all fall in bucket 0; 'h20 finds it full
      add_row(OP_SEARCH, 64'h0, 32'h0, 1, NOT_FOUND, ST_MISS);
      add_row(OP_REMOVE, 64'h0, 32'h0, 1, NOT_FOUND, ST_MISS);
      add_row(OP_NONE, 64'h0, 32'h0, 1, NOT_FOUND, ST_DONE);
      add_row(OP_INSERT, 64'h0, 32'h7fff_ffff, 1, NOT_FOUND, ST_DONE);
      add_row(OP_INSERT, 64'h10, 32'h8000_0000, 1, NOT_FOUND, ST_DONE);
      add_row(OP_INSERT, '1, 32'hffff_ffff, 1, NOT_FOUND, ST_DONE);
      add_row(OP_INSERT, 64'h8000_0000_0000_0000, 32'h5, 1, NOT_FOUND, ST_DONE);
      add_row(OP_INSERT, 64'h10, 32'h7, 1, NOT_FOUND, ST_DONE);
      add_row(OP_INSERT, 64'h20, 32'h9, 1, NOT_FOUND, ST_FULL);
      add_row(OP_SEARCH, 64'h0, 32'h0, 0, '0, '0);
      add_row(OP_SEARCH, 64'h10, 32'h0, 0, '0, '0);
      add_row(OP_SEARCH, '1, 32'h0, 1, NOT_FOUND, ST_DONE);
      add_row(OP_SEARCH, 64'h20, 32'h0, 1, NOT_FOUND, ST_MISS);
      add_row(OP_REMOVE, 64'h0, 32'h0, 1, NOT_FOUND, ST_DONE);
      add_row(OP_SEARCH, 64'h10, 32'h0, 0, '0, '0);
      add_row(OP_REMOVE, 64'h10, 32'h0, 1, NOT_FOUND, ST_DONE);
      add_row(OP_SEARCH, 64'h10, 32'h0, 0, '0, '0);
      add_row(OP_REMOVE, 64'h8000_0000_0000_0000, 32'h0, 1, NOT_FOUND, ST_DONE);
      add_row(OP_REMOVE, 64'h10, 32'h0, 1, NOT_FOUND, ST_DONE);
      add_row(OP_REMOVE, 64'h10, 32'h0, 1, NOT_FOUND, ST_MISS);
      add_row(OP_NONE, '1, 32'h5555_5555, 1, NOT_FOUND, ST_DONE);
      add_row(OP_INSERT, 64'h0102_0304_0506_0708, 32'haaaa_aaaa, 1, NOT_FOUND, ST_DONE);
      add_row(OP_SEARCH, 64'h0807_0605_0403_0201, 32'h0, 1, NOT_FOUND, ST_MISS);
      add_row(OP_SEARCH, 64'h0102_0304_0506_0708, 32'h0, 0, '0, '0);
      add_row(OP_REMOVE, '1, 32'h0, 1, NOT_FOUND, ST_DONE);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
         endcase
         if (phase == 0) begin
            foreach (seq_rows[i]) send_op(seq_rows[i]);
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            row.typed = 0;
            row.value = $urandom;
            r = $urandom_range(99);
            row.opcode = (r < 38) ? OP_INSERT : (r < 72) ? OP_SEARCH :
                         (r < 95) ? OP_REMOVE : OP_NONE;
            r = $urandom_range(99);
            k = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
            if (row.opcode == OP_INSERT) begin
               if (r < 10) k = {$urandom, $urandom};
            end else if (r < 40) begin
               // aim at a stored entry of a random bucket, if it holds one, for a hit
               b = $urandom_range(BUCKETS - 1);
               if (shadow_fill[b] != 0) k = shadow_key[b][$urandom_range(shadow_fill[b] - 1)];
            end else if (r < 60) begin
               k = {$urandom, $urandom};
            end
            row.key = k;
            send_op(row);
            if ($urandom_range(99) < 2) drain();
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/bhkv_pkg.sv
hdl/bhkv_chan_if.sv
hdl/bucketed_hash_key_value_store.sv
dv/tb.sv
